>>> hw/rtl/mctp_pkg.sv
// Package for the minimum-credit thread picker.
// Holds the table size, field widths, item mode codes, status codes and the
// sequencer state type. No dependencies.
package mctp_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [VALUE_W-1:0] IDLE_PRI = 32'hFFFF_FFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_PICK    = 3'd0,
    MODE_SET_PRI = 3'd1,
    MODE_SET_RUN = 3'd2,
    MODE_CREATE  = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_EXCL = 2'd1,
    ST_NONE = 2'd2,
    ST_ZERO = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN,
    S_SUB,
    S_GRANT,
    S_RESP
  } state_e;

endpackage

>>> hw/rtl/min_credit_thread_picker_top.sv
// Top level of the minimum-credit thread picker: slot table, pick sequencer
// and output register. Depends on mctp_pkg.
//
// - Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   mode_i selects pick, set priority, set runnable, create or delete slot.
// - Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   command: chosen_slot_o and status_o.
// - Priority and credit live in two RAMs with a registered read;
//   valid and runnable bits live in flip-flops.
// - A non-pick command goes to the result state, then into the output register.
// - A pick makes a minimum pass and a subtract-and-select pass, then one grant
//   write and the result state. A runnable slot with priority zero ends the pick
//   after the first pass; with none runnable there is no grant write.
// - in_stall_o is low only while the sequencer is idle, from the cycle after a
//   result is loaded, so a new command is taken only after the previous one
//   has left the sequencer.
// - When the receiver stalls, the result holds in the output register and the
//   sequencer waits in its result cycle until the register frees up.
// - Reset clears all valid and runnable bits and the sequencer; the RAM
//   contents are meaningless until a slot is created.
module min_credit_thread_picker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mctp_pkg::MODE_W-1:0]    mode_i,
  input  logic [mctp_pkg::SLOT_W-1:0]    slot_i,
  input  logic [mctp_pkg::VALUE_W-1:0]   value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mctp_pkg::SLOT_W-1:0]    chosen_slot_o,
  output logic [mctp_pkg::STATUS_W-1:0]  status_o
);
  import mctp_pkg::*;

  // Slot flags.
  logic [SLOTS-1:0] vld_q, vld_d;
  logic [SLOTS-1:0] run_q, run_d;

  // RAMs.
  logic [VALUE_W-1:0] pri_mem [SLOTS];
  logic [VALUE_W-1:0] crd_mem [SLOTS];
  logic               pri_we, crd_we;
  logic [IDX_W-1:0]   pri_wa, crd_wa;
  logic [VALUE_W-1:0] pri_wd, crd_wd;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] pri_rd, crd_rd;

  // Sequencer.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rv_q, rv_d;
  logic [IDX_W-1:0]   ra_q, ra_d;
  logic [SLOT_W-1:0]  excl_q, excl_d;
  logic [VALUE_W-1:0] min_q, min_d;
  logic               any_run_q, any_run_d;
  logic               zero_q, zero_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   pick_q, pick_d;
  logic [VALUE_W-1:0] pick_pri_q, pick_pri_d;
  logic [VALUE_W-1:0] excl_pri_q, excl_pri_d;
  logic [IDX_W-1:0]   gnt_addr_q, gnt_addr_d;
  logic [VALUE_W-1:0] gnt_pri_q, gnt_pri_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  status_e            res_st_q, res_st_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;

  logic               in_xfer;
  logic               slot_in_range;
  logic [IDX_W-1:0]   slot_idx;
  logic               rd_en;
  logic               pass_end;
  logic               cur_vld, cur_run;
  logic [VALUE_W-1:0] eff_crd, new_crd;
  logic               excl_hit;
  logic               out_free;
  logic [31:0]        pick_wide, excl_wide;

  assign in_stall_o    = (state_q != S_IDLE);
  assign in_xfer       = in_valid_i && (state_q == S_IDLE);
  assign slot_in_range = (32'(slot_i) < 32'(SLOTS));
  assign slot_idx      = IDX_W'(slot_i);
  assign rd_en         = (cnt_q < CNT_W'(SLOTS));
  assign rd_addr       = IDX_W'(cnt_q);
  assign pass_end      = !rd_en && !rv_q;
  assign out_free      = !out_valid_q || !out_stall_i;

  // Idle-priority slots count as holding the all-ones credit.
  assign cur_vld  = vld_q[ra_q];
  assign cur_run  = run_q[ra_q];
  assign eff_crd  = (cur_vld && (pri_rd == IDLE_PRI)) ? IDLE_PRI : crd_rd;
  assign new_crd  = cur_run ? (eff_crd - min_q) : eff_crd;
  assign excl_hit = (32'(ra_q) == 32'(excl_q));
  assign pick_wide = 32'(pick_q);
  assign excl_wide = 32'(excl_q);

  always_ff @(posedge clk_i) begin
    if (pri_we) begin
      pri_mem[pri_wa] <= pri_wd;
    end
    pri_rd <= pri_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (crd_we) begin
      crd_mem[crd_wa] <= crd_wd;
    end
    crd_rd <= crd_mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rv_d        = 1'b0;
    ra_d        = ra_q;
    excl_d      = excl_q;
    min_d       = min_q;
    any_run_d   = any_run_q;
    zero_d      = zero_q;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_pri_d  = pick_pri_q;
    excl_pri_d  = excl_pri_q;
    gnt_addr_d  = gnt_addr_q;
    gnt_pri_d   = gnt_pri_q;
    res_slot_d  = res_slot_q;
    res_st_d    = res_st_q;
    vld_d       = vld_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_slot_d  = out_slot_q;
    out_st_d    = out_st_q;
    pri_we      = 1'b0;
    pri_wa      = slot_idx;
    pri_wd      = value_i;
    crd_we      = 1'b0;
    crd_wa      = slot_idx;
    crd_wd      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_slot_d = '0;
          res_st_d   = ST_DONE;
          state_d    = S_RESP;
          if (mode_i == MODE_PICK) begin
            excl_d    = slot_i;
            min_d     = IDLE_PRI;
            any_run_d = 1'b0;
            zero_d    = 1'b0;
            found_d   = 1'b0;
            cnt_d     = '0;
            state_d   = S_MIN;
          end else if (slot_in_range) begin
            case (mode_i)
              MODE_SET_PRI: begin
                pri_we = vld_q[slot_idx];
              end
              MODE_SET_RUN: begin
                if (vld_q[slot_idx]) begin
                  run_d[slot_idx] = value_i[0];
                end
              end
              MODE_CREATE: begin
                vld_d[slot_idx] = 1'b1;
                run_d[slot_idx] = 1'b1;
                pri_we          = 1'b1;
                crd_we          = 1'b1;
              end
              MODE_DELETE: begin
                vld_d[slot_idx] = 1'b0;
                run_d[slot_idx] = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_MIN: begin
        if (rd_en) begin
          rv_d  = 1'b1;
          ra_d  = rd_addr;
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (rv_q && cur_run) begin
          any_run_d = 1'b1;
          if (pri_rd == '0) begin
            zero_d = 1'b1;
          end
          if (eff_crd < min_q) begin
            min_d = eff_crd;
          end
        end
        if (pass_end) begin
          cnt_d = '0;
          if (zero_q) begin
            res_st_d = ST_ZERO;
            state_d  = S_RESP;
          end else begin
            state_d = S_SUB;
          end
        end
      end

      S_SUB: begin
        if (rd_en) begin
          rv_d  = 1'b1;
          ra_d  = rd_addr;
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (rv_q) begin
          // Write back every slot: forces idle credits and applies the subtraction.
          crd_we = 1'b1;
          crd_wa = ra_q;
          crd_wd = new_crd;
          if (cur_run && (new_crd == '0) && !excl_hit) begin
            found_d    = 1'b1;
            pick_d     = ra_q;
            pick_pri_d = pri_rd;
          end
          if (excl_hit) begin
            excl_pri_d = pri_rd;
          end
        end
        if (pass_end) begin
          if (!any_run_q) begin
            res_st_d = ST_NONE;
            state_d  = S_RESP;
          end else if (found_q) begin
            gnt_addr_d = pick_q;
            gnt_pri_d  = pick_pri_q;
            res_slot_d = pick_wide[SLOT_W-1:0];
            res_st_d   = ST_DONE;
            state_d    = S_GRANT;
          end else if (excl_wide < 32'(SLOTS)) begin
            gnt_addr_d = IDX_W'(excl_q);
            gnt_pri_d  = excl_pri_q;
            res_slot_d = excl_wide[SLOT_W-1:0];
            res_st_d   = ST_EXCL;
            state_d    = S_GRANT;
          end else begin
            res_st_d = ST_NONE;
            state_d  = S_RESP;
          end
        end
      end

      S_GRANT: begin
        crd_we  = 1'b1;
        crd_wa  = gnt_addr_q;
        crd_wd  = gnt_pri_q;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = res_slot_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      vld_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      vld_q       <= vld_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q       <= ra_d;
    excl_q     <= excl_d;
    min_q      <= min_d;
    any_run_q  <= any_run_d;
    zero_q     <= zero_d;
    found_q    <= found_d;
    pick_q     <= pick_d;
    pick_pri_q <= pick_pri_d;
    excl_pri_q <= excl_pri_d;
    gnt_addr_q <= gnt_addr_d;
    gnt_pri_q  <= gnt_pri_d;
    res_slot_q <= res_slot_d;
    res_st_q   <= res_st_d;
    out_slot_q <= out_slot_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_slot_o = out_slot_q;
  assign status_o      = out_st_q;

  // A runnable slot is always a valid slot.
  a_run_implies_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(run_q & ~vld_q) == 0)
    else $error("runnable bit set on an invalid slot");

  // RAM read data is only consumed during the two passes.
  a_rv_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == S_MIN || state_q == S_SUB))
    else $error("read data pending outside a pass");

  // The grant write is always followed by the result cycle.
  a_grant_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT) |=> (state_q == S_RESP))
    else $error("grant not followed by result");

  // A result leaving the sequencer lands in the output register.
  a_resp_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded into output register");

endmodule
